// ===== sv/idal_pkg.sv =====
// ----------------------------------------------------------------------------
// idal_pkg
// Codes and types shared by the identifier allocator files.
// ----------------------------------------------------------------------------
package idal_pkg;

   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_IMPORT = 2'd1;
   localparam logic [1:0] FUNC_FREE   = 2'd2;
   localparam logic [1:0] FUNC_RESV   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TAKEN = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [2:0] CSR_ID_TYPE = 3'd0;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_POP  = 5'b00010,
      S_GAP  = 5'b00100,
      S_CASC = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

endpackage

// ===== sv/idal_if.sv =====
// ----------------------------------------------------------------------------
// idal_req_if / idal_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface idal_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [9:0] id_value;
   modport source (output valid, func, id_value, input ready);
   modport sink   (input valid, func, id_value, output ready);
endinterface

interface idal_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] out_type;
   logic [9:0] out_number;
   logic [1:0] status;
   modport source (output valid, out_type, out_number, status, input ready);
   modport sink   (input valid, out_type, out_number, status, output ready);
endinterface

// ===== sv/idal_csr.sv =====
// ----------------------------------------------------------------------------
// idal_csr
// APB-style register port holding the type tag.
// ----------------------------------------------------------------------------
module idal_csr
   import idal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [3:0]  id_type
);
   logic [3:0] id_type_ff, id_type_in;

   always_comb begin
      id_type_in = id_type_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ID_TYPE) begin
         id_type_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_type_ff <= '0;
      end else begin
         id_type_ff <= id_type_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ID_TYPE) ? {28'd0, id_type_ff} : '0;
   assign id_type    = id_type_ff;
endmodule

// ===== sv/id_allocator_free_list.sv =====
// ----------------------------------------------------------------------------
// id_allocator_free_list
// Identifier allocator: high-water counter plus an ordered free queue.
// ----------------------------------------------------------------------------
// One request word at a time. Allocate from the counter, import of the
// counter value, free append and every request that only reports a status
// are answered from the accept state; allocate from the queue first passes
// through the S_POP state. Import into a gap writes one skipped number per
// cycle. Import of a lower number runs one compaction pass over the queue
// in its single RAM, one entry per cycle. A free of the top number runs an
// S_CASC step and a pass for every number the cascade reclaims, and one
// more step and pass to find its end unless the counter reaches zero. The
// queue is a circular buffer of MAX_IDS entries; no entry is read before
// being written, so there is no clear pass.
// ----------------------------------------------------------------------------
module id_allocator_free_list
   import idal_pkg::*;
#(
   parameter int MAX_IDS = 1024
)(
   input  logic        clock,
   input  logic        reset,
   idal_req_if.sink    req_ch,
   idal_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_IDS);
   localparam int CW = $clog2(MAX_IDS + 1);
   localparam int EW = ((CW > 10) ? CW : 10) + 2;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == AW'(MAX_IDS - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [3:0] id_type;

   idal_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .id_type
   );

   logic [9:0] mem [MAX_IDS];
   logic [9:0] rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic [9:0] wdata;
   logic       we;

   state_type state_ff, state_in;
   logic [CW-1:0] hw_ff, hw_in, cnt_ff, cnt_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0] left_ff, left_in, kept_ff, kept_in;
   logic          pend_ff, pend_in;
   logic          mode_free_ff, mode_free_in;   // scan belongs to a free cascade
   logic [CW-1:0] val_ff, val_in;               // scan match or gap cursor
   logic [CW-1:0] tgt_ff, tgt_in;               // import target
   logic          rv_ff, rv_in;
   logic [9:0]    rnum_ff, rnum_in;
   logic [1:0]    rst_ff, rst_in;

   logic          accept;
   logic [EW-1:0] v_w, hw_w, cnt_w;
   logic          issue;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign v_w   = EW'(req_ch.id_value);
   assign hw_w  = EW'(hw_ff);
   assign cnt_w = EW'(cnt_ff);
   assign issue = (left_ff != '0);

   always_comb begin
      state_in = state_ff;  hw_in = hw_ff;  cnt_in = cnt_ff;
      head_in = head_ff;    tail_in = tail_ff;
      rd_in = rd_ff;        wr_in = wr_ff;   left_in = left_ff;  kept_in = kept_ff;
      pend_in = 1'b0;       mode_free_in = mode_free_ff;
      val_in = val_ff;      tgt_in = tgt_ff;
      rv_in = rv_ff && !rsp_ch.ready;
      rnum_in = rnum_ff;    rst_in = rst_ff;
      we = 1'b0;            waddr = tail_ff;  wdata = '0;
      raddr = (state_ff == S_SCAN) ? rd_ff : head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rv_in = 1'b1;  rnum_in = '0;  rst_in = ST_OK;
               unique case (req_ch.func)
                  FUNC_ALLOC: begin
                     if (cnt_ff != '0) begin
                        rv_in = 1'b0;  state_in = S_POP;
                     end else if (hw_w < EW'(MAX_IDS)) begin
                        rnum_in = 10'(hw_ff);  hw_in = hw_ff + 1'b1;
                     end else begin
                        rst_in = ST_RANGE;
                     end
                  end
                  FUNC_IMPORT: begin
                     if (v_w >= EW'(MAX_IDS)) begin
                        rst_in = ST_RANGE;
                     end else if (v_w == hw_w) begin
                        rnum_in = req_ch.id_value;  hw_in = hw_ff + 1'b1;
                     end else if (v_w > hw_w) begin
                        if (cnt_w + v_w - hw_w > EW'(MAX_IDS)) begin
                           rst_in = ST_FULL;
                        end else begin
                           rv_in = 1'b0;  val_in = hw_ff;  tgt_in = CW'(req_ch.id_value);
                           state_in = S_GAP;
                        end
                     end else begin
                        rv_in = 1'b0;  val_in = CW'(req_ch.id_value);
                        tgt_in = CW'(req_ch.id_value);
                        mode_free_in = 1'b0;
                        rd_in = head_ff;  wr_in = head_ff;  left_in = cnt_ff;  kept_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  FUNC_FREE: begin
                     if (v_w >= EW'(MAX_IDS)) begin
                        rst_in = ST_RANGE;
                     end else if (hw_ff != '0 && v_w == hw_w - 1'b1) begin
                        rv_in = 1'b0;  hw_in = hw_ff - 1'b1;  state_in = S_CASC;
                     end else if (cnt_w >= EW'(MAX_IDS)) begin
                        rst_in = ST_FULL;
                     end else begin
                        we = 1'b1;  wdata = req_ch.id_value;
                        tail_in = nxt(tail_ff);  cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            rv_in = 1'b1;  rnum_in = rdata_ff;  rst_in = ST_OK;
            head_in = nxt(head_ff);  cnt_in = cnt_ff - 1'b1;
            state_in = S_IDLE;
         end
         S_GAP: begin
            we = 1'b1;  wdata = 10'(val_ff);
            tail_in = nxt(tail_ff);  cnt_in = cnt_ff + 1'b1;
            val_in = val_ff + 1'b1;
            if (val_ff + 1'b1 == tgt_ff) begin
               hw_in = tgt_ff + 1'b1;
               rv_in = 1'b1;  rnum_in = 10'(tgt_ff);  rst_in = ST_OK;
               state_in = S_IDLE;
            end
         end
         S_CASC: begin
            if (hw_ff != '0) begin
               val_in = hw_ff - 1'b1;  mode_free_in = 1'b1;
               rd_in = head_ff;  wr_in = head_ff;  left_in = cnt_ff;  kept_in = '0;
               state_in = S_SCAN;
            end else begin
               rv_in = 1'b1;  rnum_in = '0;  rst_in = ST_OK;  state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (issue) begin
               rd_in = nxt(rd_ff);  left_in = left_ff - 1'b1;  pend_in = 1'b1;
            end
            // wr trails rd, so the write never hits the entry being read
            if (pend_ff && CW'(rdata_ff) != val_ff) begin
               we = 1'b1;  waddr = wr_ff;  wdata = rdata_ff;
               wr_in = nxt(wr_ff);  kept_in = kept_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               cnt_in = kept_ff;  tail_in = wr_ff;
               if (mode_free_ff) begin
                  if (kept_ff != cnt_ff) begin
                     hw_in = hw_ff - 1'b1;  state_in = S_CASC;
                  end else begin
                     rv_in = 1'b1;  rnum_in = '0;  rst_in = ST_OK;  state_in = S_IDLE;
                  end
               end else begin
                  rv_in = 1'b1;  rnum_in = 10'(tgt_ff);
                  rst_in = (kept_ff != cnt_ff) ? ST_OK : ST_TAKEN;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hw_ff    <= '0;
         cnt_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hw_ff    <= hw_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      left_ff      <= left_in;
      kept_ff      <= kept_in;
      mode_free_ff <= mode_free_in;
      val_ff       <= val_in;
      tgt_ff       <= tgt_in;
      rnum_ff      <= rnum_in;
      rst_ff       <= rst_in;
   end

   assign rsp_ch.valid      = rv_ff;
   assign rsp_ch.out_type   = id_type;
   assign rsp_ch.out_number = rnum_ff;
   assign rsp_ch.status     = rst_ff;
endmodule

// ===== bench/tb_id_allocator_free_list.sv =====
// ----------------------------------------------------------------------------
// tb_id_allocator_free_list
// Drives allocate/import/free words into the identifier allocator, predicts
// each response from a behavioural copy of counter and free queue, and
// checks every response word field by field under random idling.
// ----------------------------------------------------------------------------
module tb_id_allocator_free_list;
   import idal_pkg::*;

   localparam int NUM_IDS  = 1024;
   localparam int CYC_LIMIT = 10000000;

   typedef struct packed {
      logic [3:0] out_type;
      logic [9:0] out_number;
      logic [1:0] status;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   idal_req_if req_ch ();
   idal_rsp_if rsp_ch ();

   id_allocator_free_list dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [3:0]  tag_reg;
   int unsigned top_id;
   int unsigned freed_ids[$];
   grant_type   pending_grants[$];

   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned cycles = 0;
   bit          quiet_sink = 1'b0;
   bit          quiet_src  = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_freed(int unsigned v);
      foreach (freed_ids[i])
         if (freed_ids[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void drop_freed(int unsigned v);
      int unsigned kept[$];
      foreach (freed_ids[i])
         if (freed_ids[i] != v) kept.insert(kept.size(), freed_ids[i]);
      freed_ids = kept;
   endfunction

   function automatic grant_type predict_grant(logic [1:0] func, int unsigned v);
      grant_type g;
      g.out_type = tag_reg;
      g.out_number = '0;
      g.status = ST_OK;
      case (func)
         FUNC_ALLOC: begin
            if (freed_ids.size() > 0) begin
               g.out_number = 10'(freed_ids.pop_front());
            end else if (top_id < NUM_IDS) begin
               g.out_number = 10'(top_id);
               top_id++;
            end else begin
               g.status = ST_RANGE;
            end
         end
         FUNC_IMPORT: begin
            if (v == top_id) begin
               g.out_number = 10'(v);
               top_id++;
            end else if (v > top_id) begin
               if (freed_ids.size() + (v - top_id) > NUM_IDS) begin
                  g.status = ST_FULL;
               end else begin
                  for (int unsigned k = top_id; k < v; k++)
                     freed_ids.insert(freed_ids.size(), k);
                  g.out_number = 10'(v);
                  top_id = v + 1;
               end
            end else if (is_freed(v)) begin
               drop_freed(v);
               g.out_number = 10'(v);
            end else begin
               g.out_number = 10'(v);
               g.status = ST_TAKEN;
            end
         end
         FUNC_FREE: begin
            if (top_id > 0 && v == top_id - 1) begin
               top_id--;
               while (top_id > 0 && is_freed(top_id - 1)) begin
                  top_id--;
                  drop_freed(top_id);
               end
            end else if (freed_ids.size() >= NUM_IDS) begin
               g.status = ST_FULL;
            end else begin
               freed_ids.insert(freed_ids.size(), v);
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // response sink: random stalls, compare with oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            grant_type got, want;
            got = '{rsp_ch.out_type, rsp_ch.out_number, rsp_ch.status};
            if (pending_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: type %0d num %0d st %0d",
                           got.out_type, got.out_number, got.status);
            end else begin
               want = pending_grants.pop_front();
               words_checked++;
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp type %0d num %0d st %0d, got %0d %0d %0d",
                              want.out_type, want.out_number, want.status,
                              got.out_type, got.out_number, got.status);
               end
            end
         end
         rsp_ch.ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 10);
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      tag_reg = data[3:0];
   endtask

   // wait for the block to drain, then let a trailing pass finish
   task automatic drain_then_set_tag(logic [3:0] tag);
      req_ch.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (3 * NUM_IDS + 20) @(posedge clock);
      csr_write(CSR_ID_TYPE, {28'd0, tag});
   endtask

   // one request word; prediction taken at acceptance, valid held into the
   // next word unless an idle cycle comes first
   task automatic send_word(logic [1:0] func, logic [9:0] v);
      if (!quiet_src)
         while ($urandom_range(99) < 10) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.id_value <= v;
      do @(posedge clock); while (!req_ch.ready);
      pending_grants.insert(pending_grants.size(), predict_grant(func, 32'(v)));
      words_sent++;
   endtask

   task automatic test_directed();
      send_word(FUNC_ALLOC, 10'h3ff);
      send_word(FUNC_ALLOC, 10'h000);
      send_word(FUNC_IMPORT, 10'd1);
      send_word(FUNC_IMPORT, 10'd2);
      send_word(FUNC_IMPORT, 10'd8);       // gap 3..7 queued
      send_word(FUNC_IMPORT, 10'd5);       // taken off the queue
      send_word(FUNC_IMPORT, 10'd0);       // already taken
      send_word(FUNC_ALLOC, 10'd0);
      send_word(FUNC_FREE, 10'd4);         // append
      send_word(FUNC_FREE, 10'd4);         // duplicate append
      send_word(FUNC_FREE, 10'd100);       // above counter
      send_word(FUNC_FREE, 10'd8);         // top, cascades
      send_word(FUNC_RESV, 10'h2aa);       // unused op
      send_word(FUNC_IMPORT, 10'h3ff);     // top of range
      send_word(FUNC_ALLOC, 10'd0);
      send_word(FUNC_FREE, 10'h3ff);       // long cascade
      send_word(FUNC_IMPORT, 10'h155);
      send_word(FUNC_FREE, 10'h155);
   endtask

   // take the whole range through one gap, reuse a few, then release it
   task automatic test_exhaustion();
      send_word(FUNC_IMPORT, 10'h3ff);
      for (int i = 0; i < 10; i++) send_word(FUNC_ALLOC, 10'd0);
      send_word(FUNC_IMPORT, 10'd7);       // taken
      for (int i = 0; i < 4; i++) send_word(FUNC_FREE, 10'd3);
      send_word(FUNC_FREE, 10'h3ff);       // cascade stops at the reused numbers
      while (top_id > 0) send_word(FUNC_FREE, 10'(top_id - 1));
   endtask

   task automatic test_queue_full();
      // 1023 skipped numbers queued, then appends until the queue is full
      send_word(FUNC_IMPORT, 10'h3ff);
      send_word(FUNC_FREE, 10'd12);
      send_word(FUNC_FREE, 10'd13);        // queue full now
      send_word(FUNC_IMPORT, 10'h3ff);     // taken
      send_word(FUNC_FREE, 10'd20);
      send_word(FUNC_FREE, 10'h3ff);       // cascade clears everything
   endtask

   task automatic test_random(int n);
      int unsigned span;
      for (int i = 0; i < n; i++) begin
         int r;
         logic [9:0] v;
         quiet_src = (i >= n / 2 && i < n / 2 + 80);
         quiet_sink = quiet_src;
         span = top_id + 12;
         r = $urandom_range(99);
         if (r < 2)       v = 10'($urandom);
         else             v = 10'($urandom_range(span > 40 ? span : 40));
         if (r < 35)      send_word(FUNC_ALLOC, 10'($urandom));
         else if (r < 60) send_word(FUNC_IMPORT, v);
         else if (r < 97) send_word(FUNC_FREE, (r < 80 && top_id > 0) ? 10'(top_id - 1) : v);
         else             send_word(FUNC_RESV, 10'($urandom));
      end
      quiet_src = 1'b0;
      quiet_sink = 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_ALLOC;
      req_ch.id_value = '0;
      tag_reg = '0;
      top_id = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_then_set_tag(4'hf);
      test_exhaustion();
      drain_then_set_tag(4'h0);
      test_queue_full();
      drain_then_set_tag(4'h9);
      test_random(280);
      drain_then_set_tag(4'h6);
      test_random(260);
      req_ch.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (3 * NUM_IDS + 20) @(posedge clock);
      $display("sent %0d request words, checked %0d responses, %0d mismatches",
               words_sent, words_checked, mismatches);
      $display("covered gaps, cascades, reuse, full queue and four type tags");
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
